// ----- rtl/core/ctir_pkg.sv -----
// Package: constants, microcode word layout and control program of the interference remover.
package ctir_pkg;

   localparam int TAPS        = 64;
   localparam int STRIDE      = 8;
   localparam int STORE_DEPTH = STRIDE * (TAPS - 1) + 1;

   localparam int DATA_W      = 8;
   localparam int ADDR_W      = $clog2(STORE_DEPTH + 1);
   localparam int CNT_W       = $clog2(TAPS);
   localparam int SUM_W       = $clog2(TAPS * 255 + 1);
   localparam int STRIDE_STEP = STRIDE % STORE_DEPTH;

   localparam logic [DATA_W-1:0] OFFSET_RESET = DATA_W'(102);

   typedef enum logic [2:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_READ_FIRST,
      STEP_READ_LOOP,
      STEP_ACC_LAST,
      STEP_WAIT_OUT,
      STEP_FINISH
   } step_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_CLEAR_BUSY,
      COND_NO_ACCEPT,
      COND_TAPS_LEFT,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_INC,
      POS_STRIDE,
      POS_LOAD_WP
   } pos_op_type;

   typedef struct packed {
      logic       take;
      logic       clr_wr;
      logic       rd;
      logic       acc;
      logic       emit;
      pos_op_type pos_op;
      cond_type   cond;
      step_type   target;
   } ucode_type;

   typedef struct packed {
      logic clear_last;
      logic accept;
      logic tap_last;
      logic out_busy;
   } flags_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{take: 1'b0, clr_wr: 1'b0, rd: 1'b0, acc: 1'b0, emit: 1'b0,
            pos_op: POS_HOLD, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_CLEAR: begin
            w.clr_wr = 1'b1;
            w.pos_op = POS_INC;
            w.cond   = COND_CLEAR_BUSY;
            w.target = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.take   = 1'b1;
            w.pos_op = POS_LOAD_WP;
            w.cond   = COND_NO_ACCEPT;
            w.target = STEP_IDLE;
         end
         STEP_READ_FIRST: begin
            w.rd     = 1'b1;
            w.pos_op = POS_STRIDE;
            w.cond   = COND_NEXT;
         end
         STEP_READ_LOOP: begin
            w.rd     = 1'b1;
            w.acc    = 1'b1;
            w.pos_op = POS_STRIDE;
            w.cond   = COND_TAPS_LEFT;
            w.target = STEP_READ_LOOP;
         end
         STEP_ACC_LAST: begin
            w.acc  = 1'b1;
            w.cond = COND_NEXT;
         end
         STEP_WAIT_OUT: begin
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_WAIT_OUT;
         end
         STEP_FINISH: begin
            w.emit   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/ctir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ctir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ctir_useq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module ctir_useq (
   input  logic                clock,
   input  logic                reset,
   input  ctir_pkg::flags_type flags,
   output ctir_pkg::ucode_type ucode
);

   ctir_pkg::step_type pc_ff;
   ctir_pkg::step_type pc_in;
   logic               jump;

   always_comb begin
      jump = 1'b0;
      case (ucode.cond)
         ctir_pkg::COND_NEXT:       jump = 1'b0;
         ctir_pkg::COND_ALWAYS:     jump = 1'b1;
         ctir_pkg::COND_CLEAR_BUSY: jump = !flags.clear_last;
         ctir_pkg::COND_NO_ACCEPT:  jump = !flags.accept;
         ctir_pkg::COND_TAPS_LEFT:  jump = !flags.tap_last;
         ctir_pkg::COND_OUT_BUSY:   jump = flags.out_busy;
         default:                   jump = 1'b1;
      endcase
      pc_in = jump ? ucode.target : ctir_pkg::step_type'(pc_ff + 3'd1);
   end

   always_comb begin
      ucode = ctir_pkg::ucode_rom(pc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ctir_pkg::STEP_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- rtl/core/ctir_datapath.sv -----
// Datapath: store addressing, tap accumulator, offset register and result register.
module ctir_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ctir_pkg::ucode_type           ucode,
   output ctir_pkg::flags_type           flags,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ctir_pkg::DATA_W-1:0]   req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ctir_pkg::DATA_W-1:0]   rsp_cleaned,
   input  logic                          csr_wr_en,
   input  logic [ctir_pkg::DATA_W-1:0]   csr_wr_data
);

   localparam int ADDR_W = ctir_pkg::ADDR_W;
   localparam int RAM_AW = $clog2(ctir_pkg::STORE_DEPTH);

   logic [ADDR_W-1:0]            pos_ff, pos_in;
   logic [ADDR_W-1:0]            wp_ff, wp_in;
   logic [ctir_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ctir_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [ctir_pkg::DATA_W-1:0]  smp_ff, smp_in;
   logic [ctir_pkg::DATA_W-1:0]  offset_ff, offset_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ctir_pkg::DATA_W-1:0]  rsp_cleaned_ff, rsp_cleaned_in;

   logic                         accept;
   logic [ADDR_W:0]              pos_step;
   logic [ctir_pkg::SUM_W-1:0]   mean_full;
   logic [ctir_pkg::DATA_W-1:0]  mean;
   logic                         ram_we;
   logic [RAM_AW-1:0]            ram_waddr;
   logic [ctir_pkg::DATA_W-1:0]  ram_wdata;
   logic [ctir_pkg::DATA_W-1:0]  ram_rdata;

   assign req_ready = ucode.take;
   assign accept    = req_valid & ucode.take;

   assign flags = '{clear_last: (pos_ff == ADDR_W'(ctir_pkg::STORE_DEPTH - 1)),
                    accept:     accept,
                    tap_last:   (cnt_ff == ctir_pkg::CNT_W'(ctir_pkg::TAPS - 1)),
                    out_busy:   rsp_valid_ff & ~rsp_ready};

   assign ram_we    = ucode.clr_wr | accept;
   assign ram_waddr = ucode.clr_wr ? pos_ff[RAM_AW-1:0] : wp_ff[RAM_AW-1:0];
   assign ram_wdata = ucode.clr_wr ? '0 : req_sample;

   ctir_ram #(
      .WIDTH (ctir_pkg::DATA_W),
      .DEPTH (ctir_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ucode.rd),
      .rd_addr (pos_ff[RAM_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign pos_step  = {1'b0, pos_ff} + (ADDR_W + 1)'(ctir_pkg::STRIDE_STEP);
   assign mean_full = sum_ff / ctir_pkg::SUM_W'(ctir_pkg::TAPS);
   assign mean      = mean_full[ctir_pkg::DATA_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      case (ucode.pos_op)
         ctir_pkg::POS_HOLD:    pos_in = pos_ff;
         ctir_pkg::POS_INC:     pos_in = pos_ff + ADDR_W'(1);
         ctir_pkg::POS_STRIDE: begin
            if (pos_step >= (ADDR_W + 1)'(ctir_pkg::STORE_DEPTH)) begin
               pos_in = ADDR_W'(pos_step - (ADDR_W + 1)'(ctir_pkg::STORE_DEPTH));
            end else begin
               pos_in = pos_step[ADDR_W-1:0];
            end
         end
         ctir_pkg::POS_LOAD_WP: pos_in = accept ? wp_ff : pos_ff;
         default:               pos_in = pos_ff;
      endcase

      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (ucode.rd) begin
         cnt_in = cnt_ff + ctir_pkg::CNT_W'(1);
      end

      sum_in = sum_ff;
      if (accept) begin
         sum_in = '0;
      end else if (ucode.acc) begin
         sum_in = sum_ff + ctir_pkg::SUM_W'(ram_rdata);
      end

      smp_in = accept ? req_sample : smp_ff;

      wp_in = wp_ff;
      if (ucode.emit) begin
         wp_in = (wp_ff == ADDR_W'(ctir_pkg::STORE_DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);
      end

      offset_in = csr_wr_en ? csr_wr_data : offset_ff;

      rsp_valid_in   = rsp_valid_ff;
      rsp_cleaned_in = rsp_cleaned_ff;
      if (ucode.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_cleaned_in = smp_ff - mean + offset_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         wp_ff        <= '0;
         offset_ff    <= ctir_pkg::OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         wp_ff        <= wp_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      sum_ff         <= sum_in;
      smp_ff         <= smp_in;
      rsp_cleaned_ff <= rsp_cleaned_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_cleaned = rsp_cleaned_ff;

endmodule

// ----- rtl/core/coherent_template_interference_removal_top.sv -----
// Top level of the coherent template interference remover.
// One store read per tap on one RAM port; a new request is taken only after the previous result is emitted.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset: synchronous, active high; offset returns to 102 and the store is then cleared
// over all STORE_DEPTH (505) entries before the first request is taken.
module coherent_template_interference_removal_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ctir_pkg::DATA_W-1:0] req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ctir_pkg::DATA_W-1:0] rsp_cleaned,
   input  logic                        csr_wr_en,
   input  logic [ctir_pkg::DATA_W-1:0] csr_wr_data
);

   ctir_pkg::ucode_type ucode;
   ctir_pkg::flags_type flags;

   ctir_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ucode (ucode)
   );

   ctir_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ucode       (ucode),
      .flags       (flags),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_cleaned (rsp_cleaned),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

// ----- rtl/core/ctir_checker.sv -----
// Port checker for the interference remover and its bind to the top level.
module ctir_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ctir_pkg::DATA_W-1:0] rsp_cleaned
);

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cleaned))
      else $error("result changed or dropped while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pend_ff != 2'd0)
      else $error("result without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while the previous one is still summed");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before the store is cleared");

endmodule

bind coherent_template_interference_removal_top ctir_checker u_checker (.*);

// ----- sim/coherent_template_interference_removal_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the coherent template interference remover: directed and random requests checked against a predictor.
module coherent_template_interference_removal_top_tb;
   import ctir_pkg::*;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_sample  = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [DATA_W-1:0] rsp_cleaned;
   logic              csr_wr_en   = 1'b0;
   logic [DATA_W-1:0] csr_wr_data = '0;

   logic [DATA_W-1:0] tmpl_store [STORE_DEPTH];
   int unsigned       wr_pos;
   logic [DATA_W-1:0] offset_reg;
   logic [DATA_W-1:0] cleaned_q [$];
   logic [DATA_W-1:0] want_cleaned;
   int unsigned       err_count   = 0;
   int unsigned       wave_tick   = 0;
   bit                tx_idle_on  = 1'b0;
   bit                rx_idle_on  = 1'b0;

   coherent_template_interference_removal_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_cleaned (rsp_cleaned),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [DATA_W-1:0] predict_cleaned(input logic [DATA_W-1:0] smp);
      int unsigned       pos;
      int unsigned       tap_sum;
      logic [DATA_W-1:0] tmpl_mean;
      tmpl_store[wr_pos] = smp;
      pos     = wr_pos;
      tap_sum = 0;
      for (int t = 0; t < TAPS; t++) begin
         tap_sum += tmpl_store[pos];
         pos = (pos + STRIDE_STEP) % STORE_DEPTH;
      end
      tmpl_mean = DATA_W'(tap_sum / TAPS);
      wr_pos    = (wr_pos + 1) % STORE_DEPTH;
      return smp - tmpl_mean + offset_reg;
   endfunction

   function automatic logic [DATA_W-1:0] gen_sample();
      int unsigned kind;
      int unsigned level;
      kind      = $urandom_range(0, 99);
      wave_tick = wave_tick + 1;
      if (kind < 50) begin
         // interference-like ramp with the stride as period, plus noise
         level = 100 + (wave_tick % STRIDE) * 12 + $urandom_range(0, 15);
         return DATA_W'(level);
      end else if (kind < 85) begin
         return DATA_W'($urandom);
      end else begin
         return kind[0] ? '1 : '0;
      end
   endfunction

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endtask

   task automatic send_sample(input logic [DATA_W-1:0] smp);
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      cleaned_q.push_back(predict_cleaned(smp));
   endtask

   task automatic send_with_gap(input logic [DATA_W-1:0] smp);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      send_sample(smp);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cleaned_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_offset(input logic [DATA_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      offset_reg = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_offset();
      logic [DATA_W-1:0] vals [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
      foreach (vals[i]) send_sample(vals[i]);
   endtask

   task automatic test_offset_extremes();
      write_offset('0);
      send_sample(8'h00);
      send_sample(8'h01);
      send_sample(8'hFF);
      send_sample(8'h00);
      write_offset('1);
      send_sample(8'hFF);
      send_sample(8'hFE);
      send_sample(8'h00);
      send_sample(8'hFF);
   endtask

   task automatic test_drain_pause();
      write_offset(OFFSET_RESET);
      repeat (3) send_sample(gen_sample());
      wait_drained();
      repeat (3) send_sample(gen_sample());
   endtask

   task automatic test_random_phases();
      logic [DATA_W-1:0] offsets [4];
      offsets = '{8'hFF, DATA_W'($urandom), 8'h00, DATA_W'($urandom)};
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         repeat (175) send_with_gap(gen_sample());
      end
   endtask

   task automatic test_steady_stream();
      write_offset(OFFSET_RESET);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (100) send_with_gap(gen_sample());
   endtask

   initial begin
      @(posedge clock);
      forever begin
         if (rx_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cleaned_q.size() == 0) begin
            note_error($sformatf("unexpected response: cleaned=%0d", rsp_cleaned));
         end else begin
            want_cleaned = cleaned_q.pop_front();
            if (rsp_cleaned !== want_cleaned)
               note_error($sformatf("cleaned: expected %0d, got %0d", want_cleaned,
                                    rsp_cleaned));
         end
      end
   end

   initial begin
      foreach (tmpl_store[i]) tmpl_store[i] = '0;
      wr_pos     = 0;
      offset_reg = OFFSET_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_offset();
      test_offset_extremes();
      test_drain_pause();
      test_random_phases();
      test_steady_stream();
      wait_drained();
      repeat (TAPS + 8) @(posedge clock);
      if (err_count == 0 && cleaned_q.size() == 0) begin
         $display("coherent_template_interference_removal_top: match");
      end else begin
         $display("coherent_template_interference_removal_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("coherent_template_interference_removal_top: mismatch");
      $finish;
   end

endmodule
